>>> hdl/gcfr_pkg.sv
// Package for the growth curve flux radius block.
// Shared constants, types and state encodings; no dependencies.
`default_nettype none
package gcfr_pkg;

  localparam int FLUX_W    = 32;
  localparam int STEP_W    = 16;
  localparam int FRAC_W    = 17;
  localparam int CNT_W     = 3;
  localparam int RAD_W     = 23;
  localparam int IDX_W     = 2;
  localparam int NFRAC     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int WIDE_W    = 52;
  localparam int NUM_W     = 49;
  localparam int DEN_W     = 33;

  localparam int DEF_MAX_STEPS     = 64;
  localparam int DEF_MAX_FRACTIONS = 4;

  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRACTION_COUNT = 3'd0,
    CFG_FRACTION_A     = 3'd1,
    CFG_FRACTION_B     = 3'd2,
    CFG_FRACTION_C     = 3'd3,
    CFG_FRACTION_D     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0]             step;
    logic [CNT_W-1:0]              cnt;
    logic [NFRAC-1:0][FRAC_W-1:0]  frac;
  } job_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_TOTAL,
    BK_MUL,
    BK_TGT,
    BK_SCAN_RD,
    BK_SCAN_CMP,
    BK_PREP,
    BK_DIV,
    BK_FIN,
    BK_OUT
  } bk_state_t;

endpackage
`default_nettype wire

>>> hdl/gcfr_if.sv
// Channel interfaces: sample input, radius output, register write.
// Depends on nothing.
`default_nettype none
interface gcfr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cumulative_flux;
  logic [15:0]        step_px;
  logic               last_sample;
  modport source(output valid, cumulative_flux, step_px, last_sample, input ready);
  modport sink(input valid, cumulative_flux, step_px, last_sample, output ready);
endinterface

interface gcfr_out_if;
  logic               valid;
  logic               ready;
  logic signed [22:0] radius;
  logic [1:0]         fraction_index;
  logic               zero_slope;
  logic               last_result;
  modport source(output valid, radius, fraction_index, zero_slope, last_result, input ready);
  modport sink(input valid, radius, fraction_index, zero_slope, last_result, output ready);
endinterface

interface gcfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/gcfr_queue.sv
// Two-entry job queue between front and back.
// Depends on nothing.
`default_nettype none
module gcfr_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              valid,
  output logic [W-1:0]      head
);
  logic [1:0][W-1:0] slot_r;
  logic              wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]        cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_data;
  end
endmodule
`default_nettype wire

>>> hdl/gcfr_front.sv
// Front end: takes samples and register writes, writes the curve store,
// and issues one job per completed curve. Depends on gcfr_pkg.
`default_nettype none
module gcfr_front import gcfr_pkg::*; #(
  parameter int MAX_STEPS     = DEF_MAX_STEPS,
  parameter int MAX_FRACTIONS = DEF_MAX_FRACTIONS,
  parameter int NW            = $clog2(MAX_STEPS + 1),
  parameter int AW            = $clog2(MAX_STEPS)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [FLUX_W-1:0]     in_flux,
  input  wire logic [STEP_W-1:0]     in_step,
  input  wire logic                  in_last,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [FRAC_W-1:0]     cfg_data,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [FLUX_W-1:0]          wr_data,
  output logic                       push,
  output job_t                       job,
  output logic [NW-1:0]              job_n,
  input  wire logic                  q_full,
  input  wire logic                  done,
  output logic                       busy
);
  localparam int LIMIT = (MAX_FRACTIONS < NFRAC) ? MAX_FRACTIONS : NFRAC;

  logic [NW-1:0]               count_r, count_nxt;
  logic                        busy_r, busy_nxt;
  logic [CNT_W-1:0]            fcnt_r;
  logic [NFRAC-1:0][FRAC_W-1:0] frac_r;
  logic                        acc, at_max;

  assign at_max    = (count_r == NW'(MAX_STEPS));
  assign in_ready  = !busy_r && !q_full;
  assign acc       = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign busy      = busy_r;
  assign wr_en     = acc;
  assign wr_addr   = at_max ? AW'(MAX_STEPS - 1) : count_r[AW-1:0];
  assign wr_data   = in_flux;
  assign push      = acc && in_last;
  assign job_n     = at_max ? count_r : count_r + NW'(1);

  always_comb begin
    job.step = in_step;
    job.cnt  = (fcnt_r > CNT_W'(LIMIT)) ? CNT_W'(LIMIT) : fcnt_r;
    for (int f = 0; f < NFRAC; f++) begin
      job.frac[f] = (frac_r[f] > FRAC_ONE) ? FRAC_ONE : frac_r[f];
    end
    count_nxt = count_r;
    if (acc) begin
      if (in_last)      count_nxt = '0;
      else if (!at_max) count_nxt = count_r + NW'(1);
    end
    busy_nxt = busy_r;
    if (push)      busy_nxt = 1'b1;
    else if (done) busy_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      busy_r  <= 1'b0;
      fcnt_r  <= CNT_W'(1);
      frac_r  <= {17'd0, 17'd0, 17'd0, 17'd32768};
    end else begin
      count_r <= count_nxt;
      busy_r  <= busy_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRACTION_COUNT: fcnt_r    <= cfg_data[CNT_W-1:0];
          CFG_FRACTION_A:     frac_r[0] <= cfg_data;
          CFG_FRACTION_B:     frac_r[1] <= cfg_data;
          CFG_FRACTION_C:     frac_r[2] <= cfg_data;
          CFG_FRACTION_D:     frac_r[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/gcfr_back.sv
// Back end: curve store, per-fraction target, serial search, radix-2
// divider and result register. Depends on gcfr_pkg.
`default_nettype none
module gcfr_back import gcfr_pkg::*; #(
  parameter int MAX_STEPS = DEF_MAX_STEPS,
  parameter int NW        = $clog2(MAX_STEPS + 1),
  parameter int AW        = $clog2(MAX_STEPS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [FLUX_W-1:0]    wr_data,
  input  wire logic                 q_valid,
  input  wire job_t                 q_job,
  input  wire logic [NW-1:0]        q_n,
  output logic                      pop,
  output logic                      done,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [RAD_W-1:0]          out_radius,
  output logic [IDX_W-1:0]          out_index,
  output logic                      out_flat,
  output logic                      out_last
);
  logic [FLUX_W-1:0] mem [MAX_STEPS];
  logic [FLUX_W-1:0] rd_data_r;
  logic [AW-1:0]     rd_addr;

  bk_state_t state_r, state_nxt;

  job_t                 job_r;
  logic [NW-1:0]        n_r;
  logic [IDX_W-1:0]     j_r;
  logic [AW-1:0]        k_r, i_r;
  logic [FLUX_W-1:0]    prev_r, x0_r, x1_r;
  logic signed [49:0]   prod_r;
  logic signed [32:0]   target_r;
  logic [NUM_W-1:0]     quo_r;
  logic [DEN_W:0]       rem_r;
  logic [DEN_W-1:0]     den_r;
  logic                 den_neg_r, flat_r;
  logic [AW+STEP_W-1:0] y0_r;
  logic [NW+STEP_W-1:0] outer_r;
  logic [5:0]           bit_r;
  logic [RAD_W-1:0]     rad_r;
  logic                 ov_r, flat_o_r, last_o_r;
  logic [RAD_W-1:0]     rad_o_r;
  logic [IDX_W-1:0]     idx_o_r;

  logic                 hit, endk, take, lastf;
  logic signed [49:0]   rnd;
  logic signed [33:0]   diff, den;
  logic [DEN_W:0]       rem_sh;
  logic                 ge;
  logic signed [WIDE_W-1:0] qv, base, r, rc, outer_w;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    hit    = $signed({rd_data_r[31], rd_data_r}) >= target_r;
    endk   = (NW'(k_r) == n_r - NW'(1));
    take   = !ov_r || out_ready;
    lastf  = ({1'b0, j_r} + CNT_W'(1)) == job_r.cnt;
    rnd    = prod_r + 50'sd32768;
    diff   = {target_r[32], target_r} - {{2{x0_r[31]}}, x0_r};
    den    = {{2{x1_r[31]}}, x1_r} - {{2{x0_r[31]}}, x0_r};
    rem_sh = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_r};
    qv     = den_neg_r ? -$signed({3'b000, quo_r}) : $signed({3'b000, quo_r});
    base   = $signed({{(WIDE_W-AW-STEP_W){1'b0}}, y0_r});
    outer_w = $signed({{(WIDE_W-NW-STEP_W){1'b0}}, outer_r});
    r      = flat_r ? base + $signed({{(WIDE_W-STEP_W){1'b0}}, job_r.step}) : base + qv;
    rc     = (r > outer_w) ? outer_w : r;
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    done      = 1'b0;
    rd_addr   = '0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_job.cnt == '0) done = 1'b1;
          else state_nxt = BK_TOTAL;
        end
      end
      BK_TOTAL: begin
        rd_addr   = AW'(n_r - NW'(1));
        state_nxt = BK_MUL;
      end
      BK_MUL:     state_nxt = BK_TGT;
      BK_TGT:     state_nxt = BK_SCAN_RD;
      BK_SCAN_RD: begin
        rd_addr   = k_r;
        state_nxt = BK_SCAN_CMP;
      end
      BK_SCAN_CMP: state_nxt = (hit || endk) ? BK_PREP : BK_SCAN_RD;
      BK_PREP:     state_nxt = (x1_r == x0_r) ? BK_FIN : BK_DIV;
      BK_DIV:      state_nxt = (bit_r == 6'(NUM_W - 1)) ? BK_FIN : BK_DIV;
      BK_FIN:      state_nxt = BK_OUT;
      BK_OUT: begin
        if (take) begin
          if (lastf) begin
            done      = 1'b1;
            state_nxt = BK_IDLE;
          end else begin
            state_nxt = BK_TOTAL;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        job_r   <= q_job;
        n_r     <= q_n;
        outer_r <= q_n * q_job.step;
        j_r     <= '0;
      end
      BK_MUL: prod_r <= $signed(rd_data_r) * $signed({1'b0, job_r.frac[j_r]});
      BK_TGT: begin
        target_r <= (prod_r > 50'sd0) ? $signed({1'b0, rnd[47:16]}) : 33'sd0;
        k_r      <= '0;
      end
      BK_SCAN_CMP: begin
        if (hit || endk) begin
          x1_r <= rd_data_r;
          x0_r <= (k_r == '0) ? '0 : prev_r;
          i_r  <= k_r;
        end else begin
          prev_r <= rd_data_r;
          k_r    <= k_r + AW'(1);
        end
      end
      BK_PREP: begin
        flat_r    <= (x1_r == x0_r);
        quo_r     <= NUM_W'(diff[32:0]) * NUM_W'(job_r.step);
        den_neg_r <= den[33];
        den_r     <= den[33] ? DEN_W'(-den) : den[DEN_W-1:0];
        y0_r      <= i_r * job_r.step;
        rem_r     <= '0;
        bit_r     <= '0;
      end
      BK_DIV: begin
        rem_r <= ge ? rem_sh - {1'b0, den_r} : rem_sh;
        quo_r <= {quo_r[NUM_W-2:0], ge};
        bit_r <= bit_r + 6'd1;
      end
      BK_FIN: begin
        if (rc > WIDE_W'(4194303))        rad_r <= 23'h3FFFFF;
        else if (rc < -WIDE_W'(4194304))  rad_r <= 23'h400000;
        else                              rad_r <= rc[RAD_W-1:0];
      end
      BK_OUT: if (take) j_r <= j_r + IDX_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (state_r == BK_OUT && take) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_OUT && take) begin
      rad_o_r  <= rad_r;
      idx_o_r  <= j_r;
      flat_o_r <= flat_r;
      last_o_r <= lastf;
    end
  end

  assign out_valid  = ov_r;
  assign out_radius = rad_o_r;
  assign out_index  = idx_o_r;
  assign out_flat   = flat_o_r;
  assign out_last   = last_o_r;
endmodule
`default_nettype wire

>>> hdl/growth_curve_flux_radius_top.sv
// Flux radius from a cumulative growth curve; samples wait while busy or queue full.
// Curve end: the job is taken, then per fraction a serial search for the bracketing
// index k and a 49-step divider, skipped when the bracketing fluxes are equal.
// No new curve is taken until all results of the previous one are issued.
// Synchronous active-low reset clears counters and control, sets default fractions;
// datapath and curve store are not reset. Depends on gcfr_pkg, gcfr_if, submodules.
`default_nettype none
module growth_curve_flux_radius_top import gcfr_pkg::*; #(
  parameter int MAX_STEPS     = DEF_MAX_STEPS,
  parameter int MAX_FRACTIONS = DEF_MAX_FRACTIONS
) (
  input wire logic   clk,
  input wire logic   rst_n,
  gcfr_in_if.sink    in_ch,
  gcfr_out_if.source out_ch,
  gcfr_cfg_if.sink   cfg_ch
);
  localparam int NW = $clog2(MAX_STEPS + 1);
  localparam int AW = $clog2(MAX_STEPS);
  localparam int QW = $bits(job_t) + NW;

  logic              wr_en, q_push, q_full, q_pop, q_valid, done, f_busy;
  logic [AW-1:0]     wr_addr;
  logic [FLUX_W-1:0] wr_data;
  job_t              f_job, q_job;
  logic [NW-1:0]     f_n, q_n;
  logic [QW-1:0]     q_head;
  logic [RAD_W-1:0]  radius;

  gcfr_front #(.MAX_STEPS(MAX_STEPS), .MAX_FRACTIONS(MAX_FRACTIONS), .NW(NW), .AW(AW))
  u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_flux(in_ch.cumulative_flux), .in_step(in_ch.step_px),
    .in_last(in_ch.last_sample),
    .cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready),
    .cfg_index(cfg_ch.index), .cfg_data(cfg_ch.data),
    .wr_en, .wr_addr, .wr_data,
    .push(q_push), .job(f_job), .job_n(f_n), .q_full, .done, .busy(f_busy)
  );

  gcfr_queue #(.W(QW)) u_queue (
    .clk, .rst_n,
    .push(q_push), .push_data({f_n, f_job}), .full(q_full),
    .pop(q_pop), .valid(q_valid), .head(q_head)
  );

  assign q_n   = q_head[QW-1 -: NW];
  assign q_job = q_head[$bits(job_t)-1:0];

  gcfr_back #(.MAX_STEPS(MAX_STEPS), .NW(NW), .AW(AW)) u_back (
    .clk, .rst_n,
    .wr_en, .wr_addr, .wr_data,
    .q_valid, .q_job, .q_n, .pop(q_pop), .done,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_radius(radius), .out_index(out_ch.fraction_index),
    .out_flat(out_ch.zero_slope), .out_last(out_ch.last_result)
  );

  assign out_ch.radius = $signed(radius);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("job queue overflow");
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    f_busy |-> !in_ch.ready) else $error("sample taken while curve in work");
  a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> f_busy) else $error("busy not set after curve end");
endmodule
`default_nettype wire
